// ===== src/tfpc_pkg.sv =====
// ---------------------------------------------------------------------------
// Four-point calibrator package
// Shared constants, phase codes and the configuration bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package tfpc_pkg;

   // Screen geometry and retry limit.
   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;
   localparam int MAX_RETRIES   = 5;

   // Targets sit 30 pixels in from the top left and 31 in from the bottom right.
   localparam int TGT_LO  = 30;
   localparam int SPAN_X  = SCREEN_WIDTH - 31 - TGT_LO;
   localparam int SPAN_Y  = SCREEN_HEIGHT - 31 - TGT_LO;
   localparam int FRAC_W  = 17;
   localparam int SPAN_W  = $clog2(((SPAN_X > SPAN_Y) ? SPAN_X : SPAN_Y) + 1);

   // Divider sizes: unsigned dividend, signed 18-bit divisor.
   localparam int DVD_W   = SPAN_W + FRAC_W;
   localparam int DIV_W   = 18;
   localparam int MAG_W   = DIV_W - 1;
   localparam int CNT_W   = $clog2(DVD_W + 1);

   localparam logic [DVD_W-1:0] NUM_X = DVD_W'(SPAN_X) << FRAC_W;
   localparam logic [DVD_W-1:0] NUM_Y = DVD_W'(SPAN_Y) << FRAC_W;

   // Phase codes as reported on the response.
   localparam logic [2:0] PH_TL   = 3'd0;
   localparam logic [2:0] PH_BL   = 3'd1;
   localparam logic [2:0] PH_TR   = 3'd2;
   localparam logic [2:0] PH_BR   = 3'd3;
   localparam logic [2:0] PH_OK   = 3'd4;
   localparam logic [2:0] PH_FAIL = 3'd5;
   localparam logic [2:0] PH_IDLE = 3'd6;

   // Request functions.
   localparam logic [1:0] FN_START = 2'd0;
   localparam logic [1:0] FN_TOUCH = 2'd1;
   localparam logic [1:0] FN_END   = 2'd2;
   localparam logic [1:0] FN_LOAD  = 2'd3;

   // Orientation codes.
   localparam logic [1:0] OR_NONE = 2'd0;
   localparam logic [1:0] OR_LAND = 2'd1;
   localparam logic [1:0] OR_PORT = 2'd2;

   // Register indexes.
   localparam logic [2:0] RG_PRECISION = 3'd0;
   localparam logic [2:0] RG_SCALE_X   = 3'd1;
   localparam logic [2:0] RG_SCALE_Y   = 3'd2;
   localparam logic [2:0] RG_OFS_X     = 3'd3;
   localparam logic [2:0] RG_OFS_Y     = 3'd4;
   localparam logic [2:0] RG_ORIENT    = 3'd5;

   localparam logic [6:0] PRECISION_RESET = 7'd80;

   typedef struct packed {
      logic [6:0]         precision;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [15:0] ofs_x;
      logic signed [15:0] ofs_y;
      logic [1:0]         orientation;
   } cfg_type;

endpackage

`default_nettype wire

// ===== src/tfpc_csr.sv =====
// ---------------------------------------------------------------------------
// Calibrator register file
// APB-style write and read access to the precision and default registers.
// ---------------------------------------------------------------------------
`default_nettype none

module tfpc_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            psel,
   input  wire logic            penable,
   input  wire logic            pwrite,
   input  wire logic [4:0]      paddr,
   input  wire logic [31:0]     pwdata,
   output logic [31:0]          prdata,
   output tfpc_pkg::cfg_type    cfg
);

   tfpc_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;

   assign wr_en = psel & penable & pwrite;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[4:2])
            tfpc_pkg::RG_PRECISION: cfg_in.precision   = pwdata[6:0];
            tfpc_pkg::RG_SCALE_X:   cfg_in.scale_x     = pwdata;
            tfpc_pkg::RG_SCALE_Y:   cfg_in.scale_y     = pwdata;
            tfpc_pkg::RG_OFS_X:     cfg_in.ofs_x       = pwdata[15:0];
            tfpc_pkg::RG_OFS_Y:     cfg_in.ofs_y       = pwdata[15:0];
            tfpc_pkg::RG_ORIENT:    cfg_in.orientation = pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{precision: tfpc_pkg::PRECISION_RESET, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux.
   always_comb begin
      unique case (paddr[4:2])
         tfpc_pkg::RG_PRECISION: prdata = {25'd0, cfg_ff.precision};
         tfpc_pkg::RG_SCALE_X:   prdata = cfg_ff.scale_x;
         tfpc_pkg::RG_SCALE_Y:   prdata = cfg_ff.scale_y;
         tfpc_pkg::RG_OFS_X:     prdata = {{16{cfg_ff.ofs_x[15]}}, cfg_ff.ofs_x};
         tfpc_pkg::RG_OFS_Y:     prdata = {{16{cfg_ff.ofs_y[15]}}, cfg_ff.ofs_y};
         tfpc_pkg::RG_ORIENT:    prdata = {30'd0, cfg_ff.orientation};
         default:                prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/tfpc_divider.sv =====
// ---------------------------------------------------------------------------
// Calibrator divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
`default_nettype none

module tfpc_divider (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [tfpc_pkg::DVD_W-1:0]      dividend,
   input  wire logic signed [tfpc_pkg::DIV_W-1:0] divisor,
   output logic                                 done,
   output logic signed [31:0]                   quotient
);

   logic [tfpc_pkg::CNT_W-1:0] count_ff, count_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic                       neg_ff, neg_in;
   logic [tfpc_pkg::MAG_W-1:0] mag_ff, mag_in;
   logic [tfpc_pkg::MAG_W-1:0] rem_ff, rem_in;
   logic [tfpc_pkg::DVD_W-1:0] dq_ff, dq_in;
   logic [tfpc_pkg::MAG_W:0]   shifted;
   logic [tfpc_pkg::MAG_W:0]   diff;
   logic                       ge;
   logic [31:0]                q_ext;

   assign shifted = {rem_ff, dq_ff[tfpc_pkg::DVD_W-1]};
   assign diff    = shifted - {1'b0, mag_ff};
   assign ge      = shifted >= {1'b0, mag_ff};

   // One restoring step per cycle; the quotient shifts in behind the dividend.
   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      dq_in    = dq_ff;
      if (start) begin
         neg_in   = divisor[tfpc_pkg::DIV_W-1];
         mag_in   = divisor[tfpc_pkg::DIV_W-1] ? tfpc_pkg::MAG_W'(-divisor)
                                               : divisor[tfpc_pkg::MAG_W-1:0];
         rem_in   = '0;
         dq_in    = dividend;
         count_in = tfpc_pkg::CNT_W'(tfpc_pkg::DVD_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = ge ? diff[tfpc_pkg::MAG_W-1:0] : shifted[tfpc_pkg::MAG_W-1:0];
         dq_in    = {dq_ff[tfpc_pkg::DVD_W-2:0], ge};
         count_in = count_ff - 1'b1;
         if (count_ff == tfpc_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
   end

   assign q_ext    = 32'(dq_ff);
   assign quotient = neg_ff ? -q_ext : q_ext;
   assign done     = done_ff;

endmodule

`default_nettype wire

// ===== src/touch_four_point_calibrator.sv =====
// ---------------------------------------------------------------------------
// Four-point touch screen calibrator
// Collects four corner touches, checks precision, and computes Q17 scales
// and pixel offsets with a shared divider and multiplier.
// ---------------------------------------------------------------------------
//
//   Port group   Direction   Moves
//   req_*        in          one request: func, raw_x, raw_y
//   rsp_*        out         one response per request: phase and coefficients
//   p*           in/out      register writes and reads, always ready
//
// Start, end, load and ordinary touches are handled in the idle state; the response is
// registered and the block takes no new request until it has been taken.
// The fourth touch runs eight precision checks, one per cycle, then a decide
// state, then, if an orientation passes, two divisions on the divider and two offset multiplies.
// Reset is synchronous and clears all control state and coefficients.
// ---------------------------------------------------------------------------
`default_nettype none

module touch_four_point_calibrator (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [1:0]   req_func,
   input  wire logic [15:0]  req_raw_x,
   input  wire logic [15:0]  req_raw_y,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [2:0]        rsp_phase,
   output logic signed [31:0] rsp_scale_x,
   output logic signed [31:0] rsp_scale_y,
   output logic signed [15:0] rsp_ofs_x,
   output logic signed [15:0] rsp_ofs_y,
   output logic [1:0]        rsp_orientation,
   output logic              rsp_loaded,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [4:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_CHECK  = 8'b00000010,
      ST_DECIDE = 8'b00000100,
      ST_DIV_X  = 8'b00001000,
      ST_DIV_Y  = 8'b00010000,
      ST_OFF_X  = 8'b00100000,
      ST_OFF_Y  = 8'b01000000,
      ST_FIN    = 8'b10000000
   } state_type;

   tfpc_pkg::cfg_type cfg;

   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         phase_ff, phase_in;
   logic signed [31:0] scale_x_ff, scale_x_in;
   logic signed [31:0] scale_y_ff, scale_y_in;
   logic signed [15:0] ofs_x_ff, ofs_x_in;
   logic signed [15:0] ofs_y_ff, ofs_y_in;
   logic [1:0]         orient_ff, orient_in;
   logic [2:0]         retry_ff, retry_in;
   logic [2:0]         step_ff, step_in;
   logic               land_ok_ff, land_ok_in;
   logic               port_ok_ff, port_ok_in;
   logic               port_sel_ff, port_sel_in;
   logic signed [49:0] prod_ff, prod_in;
   logic [31:0]        tl_ff, tl_in, bl_ff, bl_in, tr_ff, tr_in, br_ff, br_in;

   logic               accept;
   logic [15:0]        rx0, rx1, rx2, rx3, ry0, ry1, ry2, ry3;
   logic signed [17:0] ldx, ldy, pdx, pdy;
   logic [16:0]        sum_x, sum_y;
   logic [15:0]        chk_a, chk_b, chk_hi, chk_lo;
   logic [23:0]        chk_lhs, chk_rhs;
   logic [7:0]         prec_p1;
   logic               chk_pass;
   logic               land_go, port_go, dflt_zero, again;
   logic               div_start, div_done;
   logic [tfpc_pkg::DVD_W-1:0]       div_num;
   logic signed [tfpc_pkg::DIV_W-1:0] div_den;
   logic signed [31:0] div_q;
   logic [16:0]        mul_a;
   logic signed [31:0] mul_b;
   logic signed [49:0] mul_full;

   // Register file.
   tfpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );
   assign pready = 1'b1;

   // Shared divider for the two scale factors.
   tfpc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   assign accept    = req_valid & ~req_stall;
   assign req_stall = (state_ff != ST_IDLE) | rsp_valid_ff;

   // Corner readings: 0 top left, 1 bottom left, 2 top right, 3 bottom right.
   assign rx0 = tl_ff[15:0];  assign ry0 = tl_ff[31:16];
   assign rx1 = bl_ff[15:0];  assign ry1 = bl_ff[31:16];
   assign rx2 = tr_ff[15:0];  assign ry2 = tr_ff[31:16];
   assign rx3 = br_ff[15:0];  assign ry3 = br_ff[31:16];

   // Scale divisors for both orientations.
   assign ldx = 18'(rx3) + 18'(rx2) - 18'(rx1) - 18'(rx0);
   assign ldy = 18'(ry3) - 18'(ry2) + 18'(ry1) - 18'(ry0);
   assign pdx = 18'(ry3) + 18'(ry2) - 18'(ry1) - 18'(ry0);
   assign pdy = 18'(rx3) - 18'(rx2) + 18'(rx1) - 18'(rx0);

   // Raw sums for the offsets of the chosen orientation.
   assign sum_x = port_sel_ff ? 17'(ry0) + 17'(ry1) : 17'(rx0) + 17'(rx1);
   assign sum_y = port_sel_ff ? 17'(rx0) + 17'(rx2) : 17'(ry0) + 17'(ry2);

   // Pair selection for the precision checks: four landscape, then four portrait.
   always_comb begin
      case (step_ff)
         3'd0:    begin chk_a = rx0; chk_b = rx1; end
         3'd1:    begin chk_a = rx2; chk_b = rx3; end
         3'd2:    begin chk_a = ry0; chk_b = ry2; end
         3'd3:    begin chk_a = ry1; chk_b = ry3; end
         3'd4:    begin chk_a = ry0; chk_b = ry1; end
         3'd5:    begin chk_a = ry2; chk_b = ry3; end
         3'd6:    begin chk_a = rx0; chk_b = rx2; end
         default: begin chk_a = rx1; chk_b = rx3; end
      endcase
   end

   // The ratio test 100*lo/hi > p is the same as 100*lo >= (p+1)*hi.
   assign chk_hi   = (chk_a > chk_b) ? chk_a : chk_b;
   assign chk_lo   = (chk_a > chk_b) ? chk_b : chk_a;
   assign prec_p1  = {1'b0, cfg.precision} + 8'd1;
   assign chk_lhs  = 24'(chk_lo) * 24'd100;
   assign chk_rhs  = 24'(chk_hi) * 24'(prec_p1);
   assign chk_pass = (chk_hi != 16'd0) && (chk_lhs >= chk_rhs);

   assign land_go   = land_ok_ff && (ldx != 18'sd0) && (ldy != 18'sd0);
   assign port_go   = port_ok_ff && (pdx != 18'sd0) && (pdy != 18'sd0);
   assign dflt_zero = (cfg.scale_x == 32'sd0) && (cfg.scale_y == 32'sd0) &&
                      (cfg.ofs_x == 16'sd0) && (cfg.ofs_y == 16'sd0);
   assign again     = retry_ff < 3'(tfpc_pkg::MAX_RETRIES);

   // Shared offset multiplier: unsigned raw sum times signed scale.
   assign mul_a    = (state_ff == ST_OFF_X) ? sum_x : sum_y;
   assign mul_b    = (state_ff == ST_OFF_X) ? scale_x_ff : scale_y_ff;
   assign mul_full = $signed({1'b0, mul_a}) * mul_b;
   assign prod_in  = (state_ff == ST_OFF_X || state_ff == ST_OFF_Y) ? mul_full : prod_ff;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      phase_in     = phase_ff;
      scale_x_in   = scale_x_ff;
      scale_y_in   = scale_y_ff;
      ofs_x_in     = ofs_x_ff;
      ofs_y_in     = ofs_y_ff;
      orient_in    = orient_ff;
      retry_in     = retry_ff;
      step_in      = step_ff;
      land_ok_in   = land_ok_ff;
      port_ok_in   = port_ok_ff;
      port_sel_in  = port_sel_ff;
      tl_in        = tl_ff;
      bl_in        = bl_ff;
      tr_in        = tr_ff;
      br_in        = br_ff;
      div_start    = 1'b0;
      div_num      = tfpc_pkg::NUM_X;
      div_den      = port_sel_ff ? pdx : ldx;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               unique case (req_func)
                  tfpc_pkg::FN_START: begin
                     scale_x_in  = '0;
                     scale_y_in  = '0;
                     ofs_x_in    = '0;
                     ofs_y_in    = '0;
                     orient_in   = tfpc_pkg::OR_NONE;
                     phase_in    = tfpc_pkg::PH_TL;
                     retry_in    = '0;
                  end
                  tfpc_pkg::FN_TOUCH: begin
                     if (phase_ff < tfpc_pkg::PH_OK) begin
                        unique case (phase_ff[1:0])
                           2'd0: tl_in = {req_raw_y, req_raw_x};
                           2'd1: bl_in = {req_raw_y, req_raw_x};
                           2'd2: tr_in = {req_raw_y, req_raw_x};
                           default: br_in = {req_raw_y, req_raw_x};
                        endcase
                        if (phase_ff != tfpc_pkg::PH_BR) begin
                           phase_in = phase_ff + 3'd1;
                        end else begin
                           // Last corner: hold the response until validation ends.
                           rsp_valid_in = 1'b0;
                           step_in      = '0;
                           land_ok_in   = 1'b1;
                           port_ok_in   = 1'b1;
                           state_in     = ST_CHECK;
                        end
                     end
                  end
                  tfpc_pkg::FN_END: begin
                     phase_in = tfpc_pkg::PH_IDLE;
                  end
                  default: begin
                     if ((scale_x_ff == 32'sd0) && (scale_y_ff == 32'sd0) &&
                         (ofs_x_ff == 16'sd0) && (ofs_y_ff == 16'sd0)) begin
                        scale_x_in  = cfg.scale_x;
                        scale_y_in  = cfg.scale_y;
                        ofs_x_in    = cfg.ofs_x;
                        ofs_y_in    = cfg.ofs_y;
                        orient_in   = (cfg.orientation == 2'd3) ? tfpc_pkg::OR_NONE
                                                                : cfg.orientation;
                     end
                  end
               endcase
            end
         end

         ST_CHECK: begin
            if (step_ff[2]) port_ok_in = port_ok_ff & chk_pass;
            else            land_ok_in = land_ok_ff & chk_pass;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) state_in = ST_DECIDE;
         end

         ST_DECIDE: begin
            if (land_go || port_go) begin
               port_sel_in = ~land_go;
               orient_in   = land_go ? tfpc_pkg::OR_LAND : tfpc_pkg::OR_PORT;
               div_den     = land_go ? ldx : pdx;
               div_start   = 1'b1;
               state_in    = ST_DIV_X;
            end else begin
               // Failure: fall back to the defaults and retry while they are unset and retries remain.
               phase_in    = tfpc_pkg::PH_FAIL;
               scale_x_in  = cfg.scale_x;
               scale_y_in  = cfg.scale_y;
               ofs_x_in    = cfg.ofs_x;
               ofs_y_in    = cfg.ofs_y;
               orient_in   = (cfg.orientation == 2'd3) ? tfpc_pkg::OR_NONE
                                                       : cfg.orientation;
               if (dflt_zero) begin
                  if (retry_ff != 3'd7) retry_in = retry_ff + 3'd1;
                  if (again) phase_in = tfpc_pkg::PH_TL;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_DIV_X: begin
            if (div_done) begin
               scale_x_in = div_q;
               div_num    = tfpc_pkg::NUM_Y;
               div_den    = port_sel_ff ? pdy : ldy;
               div_start  = 1'b1;
               state_in   = ST_DIV_Y;
            end
         end

         ST_DIV_Y: begin
            if (div_done) begin
               scale_y_in = div_q;
               state_in   = ST_OFF_X;
            end
         end

         ST_OFF_X: begin
            state_in = ST_OFF_Y;
         end

         ST_OFF_Y: begin
            ofs_x_in = 16'(tfpc_pkg::TGT_LO) - prod_ff[32:17];
            state_in = ST_FIN;
         end

         default: begin
            ofs_y_in     = 16'(tfpc_pkg::TGT_LO) - prod_ff[32:17];
            phase_in     = tfpc_pkg::PH_OK;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= tfpc_pkg::PH_IDLE;
         scale_x_ff   <= '0;
         scale_y_ff   <= '0;
         ofs_x_ff     <= '0;
         ofs_y_ff     <= '0;
         orient_ff    <= tfpc_pkg::OR_NONE;
         retry_ff     <= '0;
         step_ff      <= '0;
         land_ok_ff   <= 1'b0;
         port_ok_ff   <= 1'b0;
         port_sel_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         scale_x_ff   <= scale_x_in;
         scale_y_ff   <= scale_y_in;
         ofs_x_ff     <= ofs_x_in;
         ofs_y_ff     <= ofs_y_in;
         orient_ff    <= orient_in;
         retry_ff     <= retry_in;
         step_ff      <= step_in;
         land_ok_ff   <= land_ok_in;
         port_ok_ff   <= port_ok_in;
         port_sel_ff  <= port_sel_in;
      end
      tl_ff   <= tl_in;
      bl_ff   <= bl_in;
      tr_ff   <= tr_in;
      br_ff   <= br_in;
      prod_ff <= prod_in;
   end

   // Response fields come straight from the coefficient registers.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_phase       = phase_ff;
   assign rsp_scale_x     = scale_x_ff;
   assign rsp_scale_y     = scale_y_ff;
   assign rsp_ofs_x       = ofs_x_ff;
   assign rsp_ofs_y       = ofs_y_ff;
   assign rsp_orientation = orient_ff;
   assign rsp_loaded      = (scale_x_ff != 32'sd0) || (scale_y_ff != 32'sd0) ||
                            (ofs_x_ff != 16'sd0) || (ofs_y_ff != 16'sd0);

endmodule

`default_nettype wire

// ===== verif/touch_four_point_calibrator_tb.sv =====
// ---------------------------------------------------------------------------
// Four-point calibrator testbench
// Drives start, touch, end and load requests with random idling on both
// channels. A cycle-free predictor of the calibration sequence computes the
// expected phase and coefficients for each request, and a response monitor
// compares every response with the oldest expectation.
// ---------------------------------------------------------------------------
`default_nettype none

module touch_four_point_calibrator_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]         phase;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [15:0] ofs_x;
      logic signed [15:0] ofs_y;
      logic [1:0]         orientation;
      logic               loaded;
   } calib_result_type;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 120;

   logic clock;
   logic reset;
   logic req_valid, req_stall;
   logic [1:0] req_func;
   logic [15:0] req_raw_x, req_raw_y;
   logic rsp_valid, rsp_stall;
   logic [2:0] rsp_phase;
   logic signed [31:0] rsp_scale_x, rsp_scale_y;
   logic signed [15:0] rsp_ofs_x, rsp_ofs_y;
   logic [1:0] rsp_orientation;
   logic rsp_loaded;
   logic psel, penable, pwrite;
   logic [4:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;

   touch_four_point_calibrator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_raw_x(req_raw_x), .req_raw_y(req_raw_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_phase(rsp_phase),
      .rsp_scale_x(rsp_scale_x), .rsp_scale_y(rsp_scale_y),
      .rsp_ofs_x(rsp_ofs_x), .rsp_ofs_y(rsp_ofs_y),
      .rsp_orientation(rsp_orientation), .rsp_loaded(rsp_loaded),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Predictor state: the configuration copy and the calibration registers.
   logic [6:0]         m_precision;
   logic signed [31:0] m_def_scale_x, m_def_scale_y;
   logic signed [15:0] m_def_ofs_x, m_def_ofs_y;
   logic [1:0]         m_def_orient;
   logic [2:0]         m_phase;
   logic [15:0]        m_corner_x [4];
   logic [15:0]        m_corner_y [4];
   logic signed [31:0] m_scale_x, m_scale_y;
   logic signed [15:0] m_ofs_x, m_ofs_y;
   logic [1:0]         m_orient;
   logic [2:0]         m_retries;

   calib_result_type expected_responses[$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  idle_enabled = 1'b1;

   // Clock and the cycle limit.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Ratio check of two raw readings against the precision register.
   function automatic bit ratio_passes(logic [15:0] a, logic [15:0] b);
      longint hi, lo;
      hi = (a > b) ? a : b;
      lo = (a > b) ? b : a;
      if (hi == 0) return 1'b0;
      return ((100 * lo) / hi) > longint'(m_precision);
   endfunction

   // Target minus the floored Q17 product, both wrapped to 16 bits.
   function automatic logic signed [15:0] offset_for(longint raw_sum,
                                                     logic signed [31:0] scale);
      longint prod;
      logic signed [15:0] t;
      prod = raw_sum * longint'(scale);
      t = 16'(prod >>> tfpc_pkg::FRAC_W);
      return 16'(tfpc_pkg::TGT_LO - longint'(t));
   endfunction

   function automatic bit coeffs_clear();
      return m_scale_x == 0 && m_scale_y == 0 && m_ofs_x == 0 && m_ofs_y == 0;
   endfunction

   function automatic void take_defaults();
      m_scale_x = m_def_scale_x;
      m_scale_y = m_def_scale_y;
      m_ofs_x = m_def_ofs_x;
      m_ofs_y = m_def_ofs_y;
      m_orient = (m_def_orient > tfpc_pkg::OR_PORT) ? tfpc_pkg::OR_NONE : m_def_orient;
   endfunction

   // Precision checks, orientation choice and coefficient math after the fourth touch.
   function automatic void finish_calibration();
      longint nx, ny, ldx, ldy, pdx, pdy;
      longint x0, x1, x2, x3, y0, y1, y2, y3;
      bit land, port, again;
      x0 = m_corner_x[0]; x1 = m_corner_x[1]; x2 = m_corner_x[2]; x3 = m_corner_x[3];
      y0 = m_corner_y[0]; y1 = m_corner_y[1]; y2 = m_corner_y[2]; y3 = m_corner_y[3];
      nx = longint'(tfpc_pkg::SPAN_X) * 131072;
      ny = longint'(tfpc_pkg::SPAN_Y) * 131072;
      ldx = x3 + x2 - x1 - x0;
      ldy = y3 - y2 + y1 - y0;
      pdx = y3 + y2 - y1 - y0;
      pdy = x3 - x2 + x1 - x0;
      land = ratio_passes(m_corner_x[0], m_corner_x[1]) &&
             ratio_passes(m_corner_x[2], m_corner_x[3]) &&
             ratio_passes(m_corner_y[0], m_corner_y[2]) &&
             ratio_passes(m_corner_y[1], m_corner_y[3]) && ldx != 0 && ldy != 0;
      port = ratio_passes(m_corner_y[0], m_corner_y[1]) &&
             ratio_passes(m_corner_y[2], m_corner_y[3]) &&
             ratio_passes(m_corner_x[0], m_corner_x[2]) &&
             ratio_passes(m_corner_x[1], m_corner_x[3]) && pdx != 0 && pdy != 0;
      if (land) begin
         m_phase = tfpc_pkg::PH_OK;
         m_scale_x = 32'(nx / ldx);
         m_scale_y = 32'(ny / ldy);
         m_ofs_x = offset_for(x0 + x1, m_scale_x);
         m_ofs_y = offset_for(y0 + y2, m_scale_y);
         m_orient = tfpc_pkg::OR_LAND;
      end else if (port) begin
         m_phase = tfpc_pkg::PH_OK;
         m_scale_x = 32'(nx / pdx);
         m_scale_y = 32'(ny / pdy);
         m_ofs_x = offset_for(y0 + y1, m_scale_x);
         m_ofs_y = offset_for(x0 + x2, m_scale_y);
         m_orient = tfpc_pkg::OR_PORT;
      end else begin
         m_phase = tfpc_pkg::PH_FAIL;
         take_defaults();
         if (coeffs_clear()) begin
            again = m_retries < tfpc_pkg::MAX_RETRIES;
            if (m_retries < 7) m_retries++;
            if (again) m_phase = tfpc_pkg::PH_TL;
         end
      end
   endfunction

   // Advance the predictor by one request and return the expected response.
   function automatic calib_result_type predict_calibration(logic [1:0] func,
                                                            logic [15:0] x,
                                                            logic [15:0] y);
      calib_result_type r;
      case (func)
         tfpc_pkg::FN_START: begin
            m_scale_x = 0; m_scale_y = 0; m_ofs_x = 0; m_ofs_y = 0;
            m_orient = tfpc_pkg::OR_NONE; m_phase = tfpc_pkg::PH_TL; m_retries = 0;
         end
         tfpc_pkg::FN_TOUCH: begin
            if (m_phase < tfpc_pkg::PH_OK) begin
               m_corner_x[m_phase[1:0]] = x;
               m_corner_y[m_phase[1:0]] = y;
               if (m_phase < tfpc_pkg::PH_BR) m_phase++;
               else finish_calibration();
            end
         end
         tfpc_pkg::FN_END: m_phase = tfpc_pkg::PH_IDLE;
         default: if (coeffs_clear()) take_defaults();
      endcase
      r.phase = m_phase;
      r.scale_x = m_scale_x;
      r.scale_y = m_scale_y;
      r.ofs_x = m_ofs_x;
      r.ofs_y = m_ofs_y;
      r.orientation = m_orient;
      r.loaded = !coeffs_clear();
      return r;
   endfunction

   // Response monitor and random receiver stall.
   always @(posedge clock) begin
      calib_result_type want, got;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_phase, rsp_scale_x, rsp_scale_y, rsp_ofs_x, rsp_ofs_y,
                    rsp_orientation, rsp_loaded};
            if (expected_responses.size() == 0) begin
               $display("%0t: response expected none actual %h", $time, got);
               error_count++;
            end else begin
               want = expected_responses.pop_front();
               if (got.phase !== want.phase)
                  $display("%0t: phase expected %0d actual %0d", $time, want.phase, got.phase);
               if (got.scale_x !== want.scale_x)
                  $display("%0t: scale_x expected %0d actual %0d", $time,
                           want.scale_x, got.scale_x);
               if (got.scale_y !== want.scale_y)
                  $display("%0t: scale_y expected %0d actual %0d", $time,
                           want.scale_y, got.scale_y);
               if (got.ofs_x !== want.ofs_x)
                  $display("%0t: ofs_x expected %0d actual %0d", $time,
                           want.ofs_x, got.ofs_x);
               if (got.ofs_y !== want.ofs_y)
                  $display("%0t: ofs_y expected %0d actual %0d", $time,
                           want.ofs_y, got.ofs_y);
               if (got.orientation !== want.orientation)
                  $display("%0t: orientation expected %0d actual %0d", $time,
                           want.orientation, got.orientation);
               if (got.loaded !== want.loaded)
                  $display("%0t: loaded expected %0d actual %0d", $time,
                           want.loaded, got.loaded);
               if (got !== want) error_count++;
            end
         end
         // Stall in bursts of random length.
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (idle_enabled && ($urandom_range(0, 5) == 0)) begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Send one request, with an occasional random gap before it. Valid stays high after
   // acceptance until the next gap or wait, so back-to-back requests follow.
   task automatic send_request(logic [1:0] func, logic [15:0] x, logic [15:0] y);
      int gap;
      gap = (idle_enabled && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_raw_x <= x;
      req_raw_y <= y;
      expected_responses.push_back(predict_calibration(func, x, y));
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write through a setup and an access cycle, mirrored in the predictor.
   task automatic write_register(logic [2:0] index, logic [31:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= 5'(index) << 2; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (index)
         tfpc_pkg::RG_PRECISION: m_precision = value[6:0];
         tfpc_pkg::RG_SCALE_X:   m_def_scale_x = value;
         tfpc_pkg::RG_SCALE_Y:   m_def_scale_y = value;
         tfpc_pkg::RG_OFS_X:     m_def_ofs_x = value[15:0];
         tfpc_pkg::RG_OFS_Y:     m_def_ofs_y = value[15:0];
         tfpc_pkg::RG_ORIENT:    m_def_orient = value[1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_defaults(logic [31:0] sx, logic [31:0] sy, logic [15:0] ox,
                                 logic [15:0] oy, logic [1:0] orient);
      write_register(tfpc_pkg::RG_SCALE_X, sx);
      write_register(tfpc_pkg::RG_SCALE_Y, sy);
      write_register(tfpc_pkg::RG_OFS_X, {16'h0, ox});
      write_register(tfpc_pkg::RG_OFS_Y, {16'h0, oy});
      write_register(tfpc_pkg::RG_ORIENT, {30'h0, orient});
   endtask

   // Four touches around a landscape or portrait layout with some jitter.
   task automatic touch_corners(bit portrait, int jitter);
      logic [15:0] lo, hi, a, b;
      int k;
      lo = 16'($urandom_range(200, 30000));
      hi = 16'(lo + $urandom_range(200, 30000));
      for (k = 0; k < 4; k++) begin
         a = (k >= 2) ? hi : lo;   // follows screen x
         b = k[0] ? hi : lo;       // follows screen y
         a = 16'(a + $urandom_range(0, jitter));
         b = 16'(b + $urandom_range(0, jitter));
         if (portrait) send_request(tfpc_pkg::FN_TOUCH, b, a);
         else send_request(tfpc_pkg::FN_TOUCH, a, b);
      end
   endtask

   // Directed: field extremes, every function and the named special cases.
   task automatic test_directed();
      send_request(tfpc_pkg::FN_TOUCH, 16'hFFFF, 16'hFFFF);  // touch while idle is ignored
      send_request(tfpc_pkg::FN_LOAD, 0, 0);                 // all-zero defaults
      send_request(tfpc_pkg::FN_START, 16'hFFFF, 16'h0000);
      send_request(tfpc_pkg::FN_TOUCH, 16'd0, 16'd0);        // zero readings fail the checks
      send_request(tfpc_pkg::FN_TOUCH, 16'd0, 16'hFFFF);
      send_request(tfpc_pkg::FN_TOUCH, 16'hFFFF, 16'd0);
      send_request(tfpc_pkg::FN_TOUCH, 16'hFFFF, 16'hFFFF);
      send_request(tfpc_pkg::FN_START, 0, 0);
      touch_corners(1'b0, 0);
      send_request(tfpc_pkg::FN_END, 16'h5555, 16'hAAAA);
      send_request(tfpc_pkg::FN_TOUCH, 16'h1234, 16'h4321);
      send_request(tfpc_pkg::FN_START, 0, 0);
      touch_corners(1'b1, 0);
      send_request(tfpc_pkg::FN_LOAD, 0, 0);                 // coefficients set: no load
      send_request(tfpc_pkg::FN_START, 0, 0);
      // Equal x columns give a zero divisor.
      send_request(tfpc_pkg::FN_TOUCH, 16'd1000, 16'd1000);
      send_request(tfpc_pkg::FN_TOUCH, 16'd1000, 16'd2000);
      send_request(tfpc_pkg::FN_TOUCH, 16'd1000, 16'd1000);
      send_request(tfpc_pkg::FN_TOUCH, 16'd1000, 16'd2000);
      wait_for_responses();
   endtask

   // Retries with zero defaults until the count runs out and saturates.
   task automatic test_retry_limit();
      int n;
      send_request(tfpc_pkg::FN_START, 0, 0);
      for (n = 0; n < 8 * 4; n++) send_request(tfpc_pkg::FN_TOUCH, 16'd0, 16'(n));
      wait_for_responses();
   endtask

   // Failures and loads with extreme defaults, including orientation code 3.
   task automatic test_defaults();
      write_defaults(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 2'd3);
      send_request(tfpc_pkg::FN_START, 0, 0);
      send_request(tfpc_pkg::FN_LOAD, 0, 0);
      send_request(tfpc_pkg::FN_START, 0, 0);
      repeat (4) send_request(tfpc_pkg::FN_TOUCH, 16'd0, 16'd0);
      wait_for_responses();
      write_defaults(32'd0, 32'd0, 16'd1, 16'd0, tfpc_pkg::OR_PORT);
      send_request(tfpc_pkg::FN_START, 0, 0);
      repeat (4) send_request(tfpc_pkg::FN_TOUCH, 16'hFFFF, 16'd0);
      wait_for_responses();
      write_defaults(32'd0, 32'd0, 16'd0, 16'd0, tfpc_pkg::OR_LAND);
   endtask

   // Random sequences over several precision settings.
   task automatic test_random(int count, logic [6:0] precision);
      int sent, r;
      write_register(tfpc_pkg::RG_PRECISION, {25'h0, precision});
      sent = 0;
      while (sent < count) begin
         r = $urandom_range(0, 9);
         if (r < 6) begin
            send_request(tfpc_pkg::FN_START, 16'($urandom), 16'($urandom));
            touch_corners(r[0], (r < 4) ? $urandom_range(0, 400) : $urandom_range(0, 65535));
            sent += 5;
         end else if (r == 6) begin
            send_request(tfpc_pkg::FN_TOUCH, 16'($urandom), 16'($urandom));
            sent++;
         end else if (r == 7) begin
            send_request(tfpc_pkg::FN_END, 16'($urandom), 16'($urandom));
            sent++;
         end else if (r == 8) begin
            send_request(tfpc_pkg::FN_LOAD, 16'($urandom), 16'($urandom));
            sent++;
         end else begin
            send_request(tfpc_pkg::FN_START, 0, 0);
            sent++;
         end
      end
      wait_for_responses();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_func = tfpc_pkg::FN_START; req_raw_x = '0; req_raw_y = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      m_precision = tfpc_pkg::PRECISION_RESET;
      m_def_scale_x = 0; m_def_scale_y = 0; m_def_ofs_x = 0; m_def_ofs_y = 0;
      m_def_orient = tfpc_pkg::OR_NONE;
      m_phase = tfpc_pkg::PH_IDLE; m_scale_x = 0; m_scale_y = 0; m_ofs_x = 0; m_ofs_y = 0;
      m_orient = tfpc_pkg::OR_NONE; m_retries = 0;
      for (int k = 0; k < 4; k++) begin
         m_corner_x[k] = 0; m_corner_y[k] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_retry_limit();
      test_defaults();
      test_random(250, 7'd0);
      test_random(250, 7'd100);
      test_random(150, 7'd127);
      idle_enabled = 1'b0;
      test_random(150, 7'd80);

      wait_for_responses();
      if (error_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
src/tfpc_pkg.sv
src/tfpc_csr.sv
src/tfpc_divider.sv
src/touch_four_point_calibrator.sv
verif/touch_four_point_calibrator_tb.sv
